// ===== src/pbmd_pkg.sv =====
package pbmd_pkg;

  localparam int COORD_BITS = 24;
  localparam int NUM_AXES   = 4;
  localparam int GAP_W      = COORD_BITS;
  localparam int SQ_W       = 2 * GAP_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int IN_W       = 3 * NUM_AXES * COORD_BITS;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_BYTES_W = ((ROOT_W + 7) / 8) * 8;

  typedef logic [NUM_AXES-1:0][COORD_BITS-1:0] vec_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][GAP_W-1:0] gap;
    logic                           in_box;
  } gap_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              in_box;
  } sqrt_t;

endpackage

// ===== src/pbmd_gap.sv =====
module pbmd_gap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pbmd_pkg::vec_t    lo_i,
  input  pbmd_pkg::vec_t    hi_i,
  input  pbmd_pkg::vec_t    pt_i,
  output logic              valid_o,
  output pbmd_pkg::gap_t    gap_o
);

  pbmd_pkg::gap_t gap_d, gap_q;
  logic           valid_q;

  always_comb begin
    logic signed [pbmd_pkg::COORD_BITS:0] diff;
    gap_d        = '0;
    gap_d.in_box = 1'b1;
    for (int a = 0; a < pbmd_pkg::NUM_AXES; a++) begin
      diff = '0;
      // lower test wins on an inverted box
      if ($signed(pt_i[a]) < $signed(lo_i[a])) begin
        diff = $signed({lo_i[a][pbmd_pkg::COORD_BITS-1], lo_i[a]})
             - $signed({pt_i[a][pbmd_pkg::COORD_BITS-1], pt_i[a]});
        gap_d.in_box = 1'b0;
      end else if ($signed(pt_i[a]) > $signed(hi_i[a])) begin
        diff = $signed({pt_i[a][pbmd_pkg::COORD_BITS-1], pt_i[a]})
             - $signed({hi_i[a][pbmd_pkg::COORD_BITS-1], hi_i[a]});
        gap_d.in_box = 1'b0;
      end
      gap_d.gap[a] = diff[pbmd_pkg::GAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gap_q <= gap_d;
    end
  end

  assign valid_o = valid_q;
  assign gap_o   = gap_q;

endmodule

// ===== src/pbmd_sqsum.sv =====
module pbmd_sqsum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pbmd_pkg::gap_t    gap_i,
  output logic              valid_o,
  output pbmd_pkg::sqrt_t   sum_o
);

  logic [pbmd_pkg::NUM_AXES-1:0][pbmd_pkg::SQ_W-1:0] sq_d, sq_q;
  logic                                              in_box_q;
  logic                                              sq_valid_q;
  pbmd_pkg::sqrt_t                                   sum_d, sum_q;
  logic                                              sum_valid_q;

  always_comb begin
    for (int a = 0; a < pbmd_pkg::NUM_AXES; a++) begin
      sq_d[a] = pbmd_pkg::SQ_W'(gap_i.gap[a]) * pbmd_pkg::SQ_W'(gap_i.gap[a]);
    end
  end

  // adder tree over the four squares, radicand for the root stages
  always_comb begin
    logic [pbmd_pkg::SUM_W-1:0] s01, s23;
    s01          = pbmd_pkg::SUM_W'(sq_q[0]) + pbmd_pkg::SUM_W'(sq_q[1]);
    s23          = pbmd_pkg::SUM_W'(sq_q[2]) + pbmd_pkg::SUM_W'(sq_q[3]);
    sum_d        = '0;
    sum_d.rad    = s01 + s23;
    sum_d.in_box = in_box_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else if (en_i) begin
      sq_valid_q  <= valid_i;
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q     <= sq_d;
      in_box_q <= gap_i.in_box;
      sum_q    <= sum_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign sum_o   = sum_q;

endmodule

// ===== src/pbmd_sqrt_step.sv =====
module pbmd_sqrt_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pbmd_pkg::sqrt_t   st_i,
  output logic              valid_o,
  output pbmd_pkg::sqrt_t   st_o
);

  pbmd_pkg::sqrt_t st_d, st_q;
  logic            valid_q;

  // one root bit: bring down two radicand bits, try 4*root+1
  always_comb begin
    logic [pbmd_pkg::REM_W+1:0] acc, trial;
    logic                       ge;
    acc    = {st_i.rem, st_i.rad[pbmd_pkg::SUM_W-1 -: 2]};
    trial  = (pbmd_pkg::REM_W + 2)'({st_i.root, 2'b01});
    ge     = (acc >= trial);
    st_d   = st_i;
    st_d.rad  = {st_i.rad[pbmd_pkg::SUM_W-3:0], 2'b00};
    st_d.rem  = ge ? pbmd_pkg::REM_W'(acc - trial) : pbmd_pkg::REM_W'(acc);
    st_d.root = {st_i.root[pbmd_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ===== src/point_box_min_distance_4d_core.sv =====
// Channel   | Dir | Transaction contents
// s_axis    | in  | tdata: box_min x,y,z,w / box_max x,y,z,w / point x,y,z,w (24b each)
// m_axis    | out | tdata: distance (25b, Q13.12 unsigned); tuser: inside_res
//
// The pipe has one gap stage, one square stage, one sum stage and
// 25 root stages, one bit of the restoring square root per stage.
// A transaction can enter every cycle that the pipe advances; throughput is one per clock.
// rst_ni clears the valid bits only; data registers are not reset.
// The whole pipe advances while the output register is empty or being read,
// so a stall on m_axis freezes every stage and holds s_axis_tready low.
module point_box_min_distance_4d_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // box_min_x, _y, _z, _w, box_max_x, _y, _z, _w, point_x, _y, _z, _w (low to high)
  input  logic [pbmd_pkg::IN_BYTES_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // distance, zero padded (low to high)
  output logic [pbmd_pkg::OUT_BYTES_W-1:0]   m_axis_tdata,
  // inside_res
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  localparam int C = pbmd_pkg::COORD_BITS;
  localparam int N = pbmd_pkg::NUM_AXES;

  pbmd_pkg::vec_t  lo, hi, pt;
  logic            en;
  logic            gap_valid;
  pbmd_pkg::gap_t  gap;

  logic            st_valid [0:pbmd_pkg::ROOT_W];
  pbmd_pkg::sqrt_t st       [0:pbmd_pkg::ROOT_W];

  // unpack the input transaction per axis
  always_comb begin
    for (int a = 0; a < N; a++) begin
      lo[a] = s_axis_tdata[a * C +: C];
      hi[a] = s_axis_tdata[(N + a) * C +: C];
      pt[a] = s_axis_tdata[(2 * N + a) * C +: C];
    end
  end

  // global advance: last stage is the output register
  assign en            = !st_valid[pbmd_pkg::ROOT_W] || m_axis_tready;
  assign s_axis_tready = en;

  pbmd_gap u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .lo_i    (lo),
    .hi_i    (hi),
    .pt_i    (pt),
    .valid_o (gap_valid),
    .gap_o   (gap)
  );

  pbmd_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gap_valid),
    .gap_i   (gap),
    .valid_o (st_valid[0]),
    .sum_o   (st[0])
  );

  // root pipeline, MSB of the root first
  for (genvar k = 0; k < pbmd_pkg::ROOT_W; k++) begin : g_root
    pbmd_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[k]),
      .st_i    (st[k]),
      .valid_o (st_valid[k+1]),
      .st_o    (st[k+1])
    );
  end

  assign m_axis_tvalid = st_valid[pbmd_pkg::ROOT_W];
  assign m_axis_tdata  = pbmd_pkg::OUT_BYTES_W'(st[pbmd_pkg::ROOT_W].root);
  assign m_axis_tuser  = st[pbmd_pkg::ROOT_W].in_box;

endmodule

// ===== tb/tb_point_box_min_distance_4d_core.sv =====
module tb_point_box_min_distance_4d_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Q12.12 helpers and coordinate limits
  localparam longint Q_ONE     = 4096;
  localparam longint C_MAX     = (longint'(1) << (pbmd_pkg::COORD_BITS - 1)) - 1;
  localparam longint C_MIN     = -(longint'(1) << (pbmd_pkg::COORD_BITS - 1));
  localparam int     N_RANDOM  = 1950;
  localparam int     HOLD_AT   = 600;     // sent count that starts the long output stall
  localparam int     HOLD_LEN  = 300;     // cycles m_axis_tready is held low
  localparam int     DRAIN_AT  = 1200;    // random index where the sender drains the pipe
  localparam int     TAIL_CYC  = 40;      // longer than the pipe latency
  localparam int     LIMIT_CYC = 500000;

  // One box/point query, x in the low bits of each vector
  typedef struct packed {
    pbmd_pkg::vec_t pt;
    pbmd_pkg::vec_t bmax;
    pbmd_pkg::vec_t bmin;
  } box_query_t;

  typedef struct packed {
    logic [pbmd_pkg::ROOT_W-1:0] distance;
    logic                        in_box;
  } mindist_t;

  typedef struct packed {
    box_query_t q;
    bit         typed;    // res holds a hand-computed answer
    mindist_t   res;
  } dir_row_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic [pbmd_pkg::IN_BYTES_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [pbmd_pkg::OUT_BYTES_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;

  mindist_t  pending_dist_q[$];   // expected results, oldest first
  dir_row_t  dir_rows[$];
  int        n_sent     = 0;
  int        n_checked  = 0;
  int        n_inside   = 0;
  int        n_err      = 0;
  int        n_cycles   = 0;
  int        rx_wait    = 0;
  int        rx_nxt;
  logic      rx_hold    = 1'b0;

  point_box_min_distance_4d_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: per-axis gap, exact sum of squares, floor square root
  // ---------------------------------------------------------------------------
  function automatic logic [pbmd_pkg::ROOT_W-1:0] floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    // root of a 50-bit sum fits in 25 bits; trial bits from the top down
    for (int b = pbmd_pkg::ROOT_W; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r[pbmd_pkg::ROOT_W-1:0];
  endfunction

  function automatic mindist_t predict_mindist(box_query_t q);
    longint          lo, hi, p, gap;
    longint unsigned acc;
    mindist_t        r;
    acc      = 0;
    r.in_box = 1'b1;
    for (int a = 0; a < pbmd_pkg::NUM_AXES; a++) begin
      lo = $signed(q.bmin[a]);
      hi = $signed(q.bmax[a]);
      p  = $signed(q.pt[a]);
      // lower test first: an inverted box still yields min - p below min
      if (p < lo) begin
        gap      = lo - p;
        r.in_box = 1'b0;
      end else if (p > hi) begin
        gap      = p - hi;
        r.in_box = 1'b0;
      end else begin
        gap = 0;
      end
      acc += longint'(gap * gap);
    end
    r.distance = floor_root(acc);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic pbmd_pkg::vec_t vec4(longint x, longint y, longint z, longint w);
    pbmd_pkg::vec_t v;
    v[0] = x[pbmd_pkg::COORD_BITS-1:0];
    v[1] = y[pbmd_pkg::COORD_BITS-1:0];
    v[2] = z[pbmd_pkg::COORD_BITS-1:0];
    v[3] = w[pbmd_pkg::COORD_BITS-1:0];
    return v;
  endfunction

  function automatic pbmd_pkg::vec_t splat(longint c);
    return vec4(c, c, c, c);
  endfunction

  function automatic dir_row_t mk_row(pbmd_pkg::vec_t bmin, pbmd_pkg::vec_t bmax,
                                      pbmd_pkg::vec_t pt, bit typed,
                                      longint distance, bit in_box);
    dir_row_t r;
    r.q.bmin       = bmin;
    r.q.bmax       = bmax;
    r.q.pt         = pt;
    r.typed        = typed;
    r.res.distance = distance[pbmd_pkg::ROOT_W-1:0];
    r.res.in_box   = in_box;
    return r;
  endfunction

  function automatic longint rand_coord();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      1:       return longint'($urandom_range(0, 131071)) - 65536;
      2:       return $urandom_range(0, 1) ? C_MAX - longint'($urandom_range(0, 15))
                                           : C_MIN + longint'($urandom_range(0, 15));
      default: return $signed(v[pbmd_pkg::COORD_BITS-1:0]);
    endcase
  endfunction

  function automatic longint pick_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // Per axis: mostly ordered boxes with the point placed inside, below, above
  // or on a face; some fully random triples and some inverted boxes.
  function automatic box_query_t rand_query();
    box_query_t q;
    longint     x, y, mn, mx, lo, hi, p;
    int         kind;
    for (int a = 0; a < pbmd_pkg::NUM_AXES; a++) begin
      kind = $urandom_range(0, 9);
      x    = rand_coord();
      y    = rand_coord();
      mn   = (x < y) ? x : y;
      mx   = (x < y) ? y : x;
      lo   = (kind == 9) ? mx : mn;
      hi   = (kind == 9) ? mn : mx;
      case ($urandom_range(0, 5))
        0, 1:    p = pick_between(mn, mx);
        2:       p = pick_between(C_MIN, mn);
        3:       p = pick_between(mx, C_MAX);
        4:       p = lo;
        default: p = hi;
      endcase
      if (kind < 2) begin
        lo = rand_coord();
        hi = rand_coord();
        p  = rand_coord();
      end
      q.bmin[a] = lo[pbmd_pkg::COORD_BITS-1:0];
      q.bmax[a] = hi[pbmd_pkg::COORD_BITS-1:0];
      q.pt[a]   = p[pbmd_pkg::COORD_BITS-1:0];
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call, called at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_query(box_query_t q, bit typed, mindist_t typed_res, bit drain);
    int gap;
    // bursts with no idling, and back-to-back offers while the output is held
    gap = (((n_sent / 64) % 4 == 0) || rx_hold) ? 0 : $urandom_range(0, 11);
    if (drain) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (pending_dist_q.size() != 0) @(posedge clk_i);
    end else if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.pt, q.bmax, q.bmin};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_dist_q.push_back(typed ? typed_res : predict_mindist(q));
    n_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall per transaction, checks against the oldest entry
  // ---------------------------------------------------------------------------
  task automatic check_result();
    mindist_t want;
    if (pending_dist_q.size() == 0) begin
      $display("%0t: unexpected result distance=%0d inside=%0b", $time,
               m_axis_tdata[pbmd_pkg::ROOT_W-1:0], m_axis_tuser);
      n_err++;
    end else begin
      want = pending_dist_q.pop_front();
      if (m_axis_tdata[pbmd_pkg::ROOT_W-1:0] !== want.distance) begin
        $display("%0t: distance mismatch expected=%0d actual=%0d", $time, want.distance,
                 m_axis_tdata[pbmd_pkg::ROOT_W-1:0]);
        n_err++;
      end
      if (m_axis_tuser !== want.in_box) begin
        $display("%0t: inside mismatch expected=%0b actual=%0b", $time, want.in_box,
                 m_axis_tuser);
        n_err++;
      end
      n_inside += want.in_box;
    end
    n_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wait       <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        rx_nxt = ((n_checked / 50) % 3 == 0) ? 0 : $urandom_range(0, 11);
      end else begin
        rx_nxt = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait       <= rx_nxt;
      m_axis_tready <= (rx_nxt == 0) && !rx_hold;
    end
  end

  // Long output stall: the pipe fills and must push back on s_axis
  initial begin
    wait (n_sent >= HOLD_AT);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT_CYC) begin
      $display("point_box_min_distance_4d_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // degenerate box, point on it
    dir_rows.push_back(mk_row(splat(0), splat(0), splat(0), 1, 0, 1));
    // point on lower and on upper face
    dir_rows.push_back(mk_row(splat(-Q_ONE), splat(Q_ONE), splat(-Q_ONE), 1, 0, 1));
    dir_rows.push_back(mk_row(splat(-Q_ONE), splat(Q_ONE), splat(Q_ONE), 1, 0, 1));
    // largest gap on every axis: root = 2 * (2^24 - 1)
    dir_rows.push_back(mk_row(splat(C_MAX), splat(C_MAX), splat(C_MIN), 1, 33554430, 0));
    dir_rows.push_back(mk_row(splat(C_MIN), splat(C_MIN), splat(C_MAX), 1, 33554430, 0));
    // full-range box, point at either corner
    dir_rows.push_back(mk_row(splat(C_MIN), splat(C_MAX), splat(C_MIN), 1, 0, 1));
    dir_rows.push_back(mk_row(splat(C_MIN), splat(C_MAX), splat(C_MAX), 1, 0, 1));
    // largest gap on one axis only
    dir_rows.push_back(mk_row(splat(C_MIN), splat(C_MIN), vec4(C_MAX, C_MIN, C_MIN, C_MIN),
                              1, 16777215, 0));
    // unit gaps, a 3-4-12 triple, a non-square sum
    dir_rows.push_back(mk_row(splat(0), splat(0), vec4(Q_ONE, 0, 0, 0), 1, Q_ONE, 0));
    dir_rows.push_back(mk_row(splat(0), splat(0), vec4(0, 0, 0, -Q_ONE), 1, Q_ONE, 0));
    dir_rows.push_back(mk_row(splat(0), splat(0), vec4(3, 4, 12, 0), 1, 13, 0));
    dir_rows.push_back(mk_row(splat(0), splat(0), vec4(1, -1, 0, 0), 1, 1, 0));
    // one LSB outside either face
    dir_rows.push_back(mk_row(splat(0), splat(Q_ONE), vec4(Q_ONE + 1, 0, 0, 0), 1, 1, 0));
    dir_rows.push_back(mk_row(splat(0), splat(Q_ONE), vec4(0, 0, -1, 0), 1, 1, 0));
    // inverted box: between the bounds, below min, above min, on min
    dir_rows.push_back(mk_row(splat(Q_ONE), splat(-Q_ONE), splat(0), 1, 2 * Q_ONE, 0));
    dir_rows.push_back(mk_row(splat(Q_ONE), splat(-Q_ONE), splat(-2 * Q_ONE), 1,
                              6 * Q_ONE, 0));
    dir_rows.push_back(mk_row(splat(Q_ONE), splat(-Q_ONE), splat(2 * Q_ONE), 1,
                              6 * Q_ONE, 0));
    dir_rows.push_back(mk_row(splat(Q_ONE), splat(-Q_ONE), splat(Q_ONE), 1, 4 * Q_ONE, 0));
    // mixed axes: below, above, inside, on a face
    dir_rows.push_back(mk_row(vec4(-5 * Q_ONE, -6 * Q_ONE, -7 * Q_ONE, -8 * Q_ONE),
                              vec4(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE),
                              vec4(-9 * Q_ONE - 7, 3 * Q_ONE + 11, 0, 4 * Q_ONE), 0, 0, 0));
    dir_rows.push_back(mk_row(vec4(C_MIN, 100, -100, 0), vec4(0, 200, 100, C_MAX),
                              vec4(C_MAX, 99, 101, C_MIN), 0, 0, 0));
    dir_rows.push_back(mk_row(vec4(123456, -654321, 777, -1), vec4(-123456, 654321, 778, 1),
                              vec4(0, 0, 779, 2), 0, 0, 0));
    dir_rows.push_back(mk_row(splat(-1), splat(1), vec4(2, -2, 1, -1), 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].res, 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      send_query(rand_query(), 1'b0, '0, i == DRAIN_AT);
    s_axis_tvalid <= 1'b0;

    while (pending_dist_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("%0d directed and %0d random box/point queries, %0d results checked", 
             dir_rows.size(), N_RANDOM, n_checked);
    $display("%0d inside, %0d outside; output stall and full pipe drain exercised",
             n_inside, n_checked - n_inside);
    if (n_err == 0) begin
      $display("point_box_min_distance_4d_core regression: pass");
    end else begin
      $display("point_box_min_distance_4d_core regression: fail");
    end
    $finish;
  end

endmodule
